// ----- rtl/core/fpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Fan PWM ramp and tacho package
// Shared constants, register indexes, command/status types and the
// tachometer revolution factor table.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned S_DATA_W   = 24;
  localparam int unsigned M_DATA_W   = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_REQUEST_MIN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REQUEST_MAX    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_UNIT_ON        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ADJUST_DELAY   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSES_PER_REV = 3'd4;

  localparam logic [6:0]  INITIAL_DUTY     = 7'd50;
  localparam logic [6:0]  DUTY_FULL        = 7'd100;
  localparam logic [6:0]  STEP_TICKS       = 7'd100;
  localparam logic [10:0] MEASURE_INTERVAL = 11'd2000;
  localparam logic [9:0]  WINDOW_LENGTH    = 10'd1000;

  localparam logic [7:0] RST_REQUEST_MIN    = 8'd0;
  localparam logic [7:0] RST_REQUEST_MAX    = 8'd100;
  localparam logic       RST_UNIT_ON        = 1'b1;
  localparam logic [7:0] RST_ADJUST_DELAY   = 8'd0;
  localparam logic [5:0] RST_PULSES_PER_REV = 6'd2;

  typedef struct packed {
    logic capture;
    logic edge_cnt;
    logic win;
    logic meas;
    logic ramp;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic is_edge;
    logic out_room;
  } sts_t;

  // 60 / pulses_per_rev, zero for zero pulses
  function automatic logic [5:0] rev_factor(input logic [5:0] ppr);
    logic [5:0] f;
    f = 6'd0;
    priority if (ppr == 6'd0)  f = 6'd0;
    else if (ppr == 6'd1)      f = 6'd60;
    else if (ppr == 6'd2)      f = 6'd30;
    else if (ppr == 6'd3)      f = 6'd20;
    else if (ppr == 6'd4)      f = 6'd15;
    else if (ppr == 6'd5)      f = 6'd12;
    else if (ppr == 6'd6)      f = 6'd10;
    else if (ppr == 6'd7)      f = 6'd8;
    else if (ppr == 6'd8)      f = 6'd7;
    else if (ppr <= 6'd10)     f = 6'd6;
    else if (ppr <= 6'd12)     f = 6'd5;
    else if (ppr <= 6'd15)     f = 6'd4;
    else if (ppr <= 6'd20)     f = 6'd3;
    else if (ppr <= 6'd30)     f = 6'd2;
    else if (ppr <= 6'd60)     f = 6'd1;
    else                       f = 6'd0;
    return f;
  endfunction

endpackage

// ----- rtl/core/fpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Fan PWM ramp and tacho controller
// Sequences one word through edge counting or the tick steps, then loads
// the output register.
// ----------------------------------------------------------------------------
module fpr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpr_pkg::sts_t sts_i,
  output fpr_pkg::cmd_t cmd_o
);
  import fpr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MEAS,
    S_RAMP,
    S_LOAD
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.edge_cnt = (state_q == S_EXEC) && sts_i.is_edge;
    cmd_o.win      = (state_q == S_EXEC) && !sts_i.is_edge;
    cmd_o.meas     = (state_q == S_MEAS);
    cmd_o.ramp     = (state_q == S_RAMP);
    cmd_o.load     = (state_q == S_LOAD) && sts_i.out_room;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= sts_i.is_edge ? S_LOAD : S_MEAS;
        end
        S_MEAS: state_q <= S_RAMP;
        S_RAMP: state_q <= S_LOAD;
        S_LOAD: begin
          if (sts_i.out_room) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.edge_cnt, cmd_o.win, cmd_o.meas, cmd_o.ramp, cmd_o.load}))
    else $error("more than one datapath command");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted word not executed");

  a_load_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && !sts_i.out_room) |=> (state_q == S_LOAD))
    else $error("result dropped while output full");

endmodule

// ----- rtl/core/fpr_datapath.sv -----
// ----------------------------------------------------------------------------
// Fan PWM ramp and tacho datapath
// Configuration registers, ramp and tacho state, rpm scaling and the
// output register.
// ----------------------------------------------------------------------------
module fpr_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fpr_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_func_i,
  input  logic [fpr_pkg::S_DATA_W-1:0]       in_data_i,
  input  fpr_pkg::cmd_t                      cmd_i,
  output fpr_pkg::sts_t                      sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fpr_pkg::M_DATA_W-1:0]       out_data_o
);
  import fpr_pkg::*;

  logic [7:0]  req_min_q, req_max_q, delay_q;
  logic        unit_on_q;
  logic [5:0]  ppr_q;

  logic        func_q, wd_q;
  logic [7:0]  req_n_q, req_f_q;

  logic [6:0]  duty_q;
  logic [14:0] adj_ticks_q;
  logic [10:0] meas_ticks_q;
  logic [9:0]  win_ticks_q;
  logic        counting_q;
  logic [15:0] edge_q;
  logic [15:0] rpm_q;
  logic        conv_q;

  logic        close_q, step_q;
  logic [21:0] prod_q;
  logic [14:0] period_q;

  logic        out_valid_q;
  logic [M_DATA_W-1:0] out_q;

  logic [9:0]  win_inc;
  logic [10:0] meas_inc;
  logic [14:0] adj_inc;
  logic [8:0]  delay_p1;
  logic [7:0]  req_sel, req_clamp;
  logic [6:0]  duty_step, duty_capped;
  logic [6:0]  cmp_value;

  assign win_inc  = win_ticks_q + 10'd1;
  assign meas_inc = meas_ticks_q + 11'd1;
  assign adj_inc  = adj_ticks_q + 15'd1;
  assign delay_p1 = {1'b0, delay_q} + 9'd1;

  always_comb begin
    req_sel = wd_q ? req_f_q : req_n_q;
    req_clamp = req_sel;
    if (req_clamp < req_min_q) req_clamp = req_min_q;
    if (req_clamp > req_max_q) req_clamp = req_max_q;
    if (!unit_on_q) req_clamp = 8'd0;
    duty_step = duty_q;
    if ({1'b0, duty_q} < req_clamp) duty_step = duty_q + 7'd1;
    else if ({1'b0, duty_q} > req_clamp) duty_step = duty_q - 7'd1;
    duty_capped = (duty_step > DUTY_FULL) ? DUTY_FULL : duty_step;
  end

  assign cmp_value = DUTY_FULL - duty_q;

  assign sts_o.is_edge  = func_q;
  assign sts_o.out_room = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_min_q <= RST_REQUEST_MIN;
      req_max_q <= RST_REQUEST_MAX;
      unit_on_q <= RST_UNIT_ON;
      delay_q   <= RST_ADJUST_DELAY;
      ppr_q     <= RST_PULSES_PER_REV;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_REQUEST_MIN:    req_min_q <= cfg_wdata_i;
        REG_REQUEST_MAX:    req_max_q <= cfg_wdata_i;
        REG_UNIT_ON:        unit_on_q <= cfg_wdata_i[0];
        REG_ADJUST_DELAY:   delay_q   <= cfg_wdata_i;
        REG_PULSES_PER_REV: ppr_q     <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wd_q    <= in_data_i[0];
      req_n_q <= in_data_i[8:1];
      req_f_q <= in_data_i[16:9];
    end
    if (cmd_i.win) begin
      prod_q   <= {6'd0, edge_q} * {16'd0, rev_factor(ppr_q)};
      period_q <= {6'd0, delay_p1} * {8'd0, STEP_TICKS};
    end
    if (cmd_i.load) begin
      out_q <= {counting_q, rpm_q, conv_q, cmp_value, duty_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q       <= 1'b0;
      duty_q       <= INITIAL_DUTY;
      adj_ticks_q  <= '0;
      meas_ticks_q <= '0;
      win_ticks_q  <= '0;
      counting_q   <= 1'b0;
      edge_q       <= '0;
      rpm_q        <= '0;
      conv_q       <= 1'b0;
      close_q      <= 1'b0;
      step_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) func_q <= in_func_i;

      if (cmd_i.edge_cnt && counting_q && (edge_q != 16'hFFFF)) begin
        edge_q <= edge_q + 16'd1;
      end

      if (cmd_i.win) begin
        if (counting_q) win_ticks_q <= win_inc;
        close_q <= counting_q && (win_inc >= WINDOW_LENGTH);
      end

      if (cmd_i.meas) begin
        if (close_q) begin
          rpm_q      <= (prod_q[21:16] != 6'd0) ? 16'hFFFF : prod_q[15:0];
          counting_q <= 1'b0;
        end
        if (meas_inc >= MEASURE_INTERVAL) begin
          meas_ticks_q <= '0;
          edge_q       <= '0;
          win_ticks_q  <= '0;
          counting_q   <= 1'b1;
        end else begin
          meas_ticks_q <= meas_inc;
        end
        if (adj_inc >= period_q) begin
          adj_ticks_q <= '0;
          step_q      <= 1'b1;
        end else begin
          adj_ticks_q <= adj_inc;
          step_q      <= 1'b0;
        end
      end

      if (cmd_i.ramp && step_q) begin
        duty_q <= duty_capped;
        conv_q <= !unit_on_q;
      end

      if (cmd_i.load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DUTY_FULL)
    else $error("duty above full scale");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counting_q |-> (win_ticks_q <= WINDOW_LENGTH))
    else $error("window open past its length");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_q)
    else $error("loaded word not presented");

endmodule

// ----- rtl/core/fan_pwm_ramp_and_tacho_unit.sv -----
// ----------------------------------------------------------------------------
// Fan PWM ramp and tacho unit
// Slew-limited fan duty with tachometer speed measurement.
//
// Input stream: one word per millisecond tick (tuser 0) or per tachometer
// rising edge (tuser 1); tdata carries the watchdog flag and both requests.
// Output stream: one word per input word with duty, compare value,
// converter-off flag, last measured rpm and the window-open flag.
// Configuration: cfg_we_i writes register cfg_addr_i at the clock edge.
// Sequence: an edge word goes from accept through edge count to output load,
// a tick word through window/multiply, measure/ramp timers, ramp and output
// load, set by the controller sequence. One word is in flight at a time, so
// the next word is accepted only after the last one has been loaded.
// The output register holds a finished word while the receiver stalls; the
// next input word is accepted and processed, then waits for the load.
// Reset restores register defaults, duty 50 and clears all counters.
// ----------------------------------------------------------------------------
module fan_pwm_ramp_and_tacho_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fpr_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] watchdog_expired, [8:1] fan_request, [16:9] fallback_request, zero pad
  input  logic [fpr_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // [0] func
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [6:0] duty_percent, [13:7] compare_value, [14] converter_off,
  // [30:15] speed_rpm, [31] window_open
  output logic [fpr_pkg::M_DATA_W-1:0]      m_axis_tdata
);
  import fpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_func_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
